>>> rtl/spp_pkg.sv
// Shared types, codes and constants for the stack push/pop unit.
package spp_pkg;

  // Default memory address width (stack memory holds 2**ADDR_BITS bytes)
  localparam int ADDR_BITS_DEF = 16;

  // Instruction codes
  localparam logic [2:0] MODE_PUSH_PAIR = 3'd0;
  localparam logic [2:0] MODE_PUSH_ST   = 3'd1;
  localparam logic [2:0] MODE_POP_PAIR  = 3'd2;
  localparam logic [2:0] MODE_POP_ST    = 3'd3;
  localparam logic [2:0] MODE_XCHG      = 3'd4;
  localparam logic [2:0] MODE_LOAD_SP   = 3'd5;

  // Address select
  localparam logic [1:0] ADDR_SP    = 2'd0;
  localparam logic [1:0] ADDR_SP_M1 = 2'd1;
  localparam logic [1:0] ADDR_SP_P1 = 2'd2;

  // Write data select
  localparam logic [1:0] WD_HI = 2'd0;
  localparam logic [1:0] WD_LO = 2'd1;
  localparam logic [1:0] WD_ST = 2'd2;

  // Stack pointer update
  localparam logic [1:0] SP_HOLD = 2'd0;
  localparam logic [1:0] SP_DEC  = 2'd1;
  localparam logic [1:0] SP_INC  = 2'd2;
  localparam logic [1:0] SP_LOAD = 2'd3;

  // Capture of the byte read in the previous cycle
  localparam logic [1:0] CAP_NONE = 2'd0;
  localparam logic [1:0] CAP_LO   = 2'd1;
  localparam logic [1:0] CAP_HI   = 2'd2;
  localparam logic [1:0] CAP_ST   = 2'd3;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] high_in;
    logic [7:0] low_in;
    logic       pair_is_sp;
    logic       carry_in;
    logic       parity_in;
    logic       aux_carry_in;
    logic       zero_in;
    logic       sign_in;
  } in_t;

  typedef struct packed {
    logic [7:0]  high_out;
    logic [7:0]  low_out;
    logic        carry_out;
    logic        parity_out;
    logic        aux_carry_out;
    logic        zero_out;
    logic        sign_out;
    logic [15:0] stack_ptr_out;
    logic        refused;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_item;
    logic       mem_we;
    logic       mem_re;
    logic [1:0] addr_sel;
    logic [1:0] wd_sel;
    logic [1:0] sp_op;
    logic [1:0] cap;
    logic       set_refused;
    logic       done;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] mode;
    logic       pair_is_sp;
  } stat_t;

endpackage

>>> rtl/spp_ctrl.sv
// Controller state machine: sequences the memory accesses of each instruction.
module spp_ctrl import spp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STEP1 = 3'd1;
  localparam logic [2:0] ST_STEP2 = 3'd2;
  localparam logic [2:0] ST_STEP3 = 3'd3;
  localparam logic [2:0] ST_STEP4 = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Decode state and instruction into commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_STEP1;
        end
      end
      ST_STEP1: begin
        case (stat.mode)
          MODE_PUSH_PAIR, MODE_PUSH_ST: begin
            if (stat.mode == MODE_PUSH_PAIR && stat.pair_is_sp) begin
              cmd.set_refused = 1'b1;
              cmd.done        = 1'b1;
              state_nxt       = ST_IDLE;
            end else begin
              cmd.mem_we   = 1'b1;
              cmd.addr_sel = ADDR_SP_M1;
              cmd.wd_sel   = WD_HI;
              cmd.sp_op    = SP_DEC;
              state_nxt    = ST_STEP2;
            end
          end
          MODE_POP_PAIR, MODE_POP_ST: begin
            if (stat.mode == MODE_POP_PAIR && stat.pair_is_sp) begin
              cmd.set_refused = 1'b1;
              cmd.done        = 1'b1;
              state_nxt       = ST_IDLE;
            end else begin
              cmd.mem_re   = 1'b1;
              cmd.addr_sel = ADDR_SP;
              cmd.sp_op    = SP_INC;
              state_nxt    = ST_STEP2;
            end
          end
          MODE_XCHG: begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = ADDR_SP;
            state_nxt    = ST_STEP2;
          end
          MODE_LOAD_SP: begin
            cmd.sp_op = SP_LOAD;
            cmd.done  = 1'b1;
            state_nxt = ST_IDLE;
          end
          default: begin
            cmd.done  = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_STEP2: begin
        case (stat.mode)
          MODE_PUSH_PAIR, MODE_PUSH_ST: begin
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = ADDR_SP_M1;
            cmd.wd_sel   = (stat.mode == MODE_PUSH_ST) ? WD_ST : WD_LO;
            cmd.sp_op    = SP_DEC;
            cmd.done     = 1'b1;
            state_nxt    = ST_IDLE;
          end
          MODE_POP_PAIR, MODE_POP_ST: begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = ADDR_SP;
            cmd.sp_op    = SP_INC;
            cmd.cap      = (stat.mode == MODE_POP_ST) ? CAP_ST : CAP_LO;
            state_nxt    = ST_STEP3;
          end
          MODE_XCHG: begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = ADDR_SP_P1;
            cmd.cap      = CAP_LO;
            state_nxt    = ST_STEP3;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_STEP3: begin
        case (stat.mode)
          MODE_XCHG: begin
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = ADDR_SP;
            cmd.wd_sel   = WD_LO;
            cmd.cap      = CAP_HI;
            state_nxt    = ST_STEP4;
          end
          default: begin
            cmd.cap   = CAP_HI;
            cmd.done  = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_STEP4: begin
        cmd.mem_we   = 1'b1;
        cmd.addr_sel = ADDR_SP_P1;
        cmd.wd_sel   = WD_HI;
        cmd.done     = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> rtl/spp_dp.sv
// Datapath: stack pointer, stack memory, item register and result registers.
module spp_dp import spp_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   in_item,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  out_valid,
  output out_t  out_item
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [7:0]           mem [DEPTH];
  in_t                  item_r;
  logic [15:0]          sp_r;
  logic [15:0]          sp_nxt;
  logic [15:0]          addr16;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           wdata;
  logic [7:0]           status_byte;
  logic [7:0]           mem_rd_r;
  logic [7:0]           res_hi_r;
  logic [7:0]           res_lo_r;
  logic [7:0]           res_st_r;
  logic                 refused_r;
  logic                 out_valid_r;

  // Pack the flag byte: bit 1 set, bits 3 and 5 clear
  assign status_byte = {item_r.sign_in, item_r.zero_in, 1'b0, item_r.aux_carry_in,
                        1'b0, item_r.parity_in, 1'b1, item_r.carry_in};

  // Select memory address
  always_comb begin
    case (cmd.addr_sel)
      ADDR_SP_M1: addr16 = sp_r - 16'd1;
      ADDR_SP_P1: addr16 = sp_r + 16'd1;
      default:    addr16 = sp_r;
    endcase
  end
  assign mem_addr = addr16[ADDR_BITS-1:0];

  // Select write data
  always_comb begin
    case (cmd.wd_sel)
      WD_LO:   wdata = item_r.low_in;
      WD_ST:   wdata = status_byte;
      default: wdata = item_r.high_in;
    endcase
  end

  // Update stack pointer
  always_comb begin
    case (cmd.sp_op)
      SP_DEC:  sp_nxt = sp_r - 16'd1;
      SP_INC:  sp_nxt = sp_r + 16'd1;
      SP_LOAD: sp_nxt = {item_r.high_in, item_r.low_in};
      default: sp_nxt = sp_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= 16'd0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  // Single-port stack memory with registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[mem_addr] <= wdata;
    end
    if (cmd.mem_re) begin
      mem_rd_r <= mem[mem_addr];
    end
  end

  // Hold the item; clear results when a new item arrives, then capture bytes
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r    <= in_item;
      res_hi_r  <= 8'd0;
      res_lo_r  <= 8'd0;
      res_st_r  <= 8'd0;
      refused_r <= 1'b0;
    end else begin
      case (cmd.cap)
        CAP_LO:  res_lo_r <= mem_rd_r;
        CAP_HI:  res_hi_r <= mem_rd_r;
        CAP_ST:  res_st_r <= mem_rd_r;
        default: ;
      endcase
      if (cmd.set_refused) begin
        refused_r <= 1'b1;
      end
    end
  end

  // Strobe the result for one cycle after the last step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.done;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_item               = '0;
    out_item.high_out      = res_hi_r;
    out_item.low_out       = res_lo_r;
    out_item.carry_out     = res_st_r[0];
    out_item.parity_out    = res_st_r[2];
    out_item.aux_carry_out = res_st_r[4];
    out_item.zero_out      = res_st_r[6];
    out_item.sign_out      = res_st_r[7];
    out_item.stack_ptr_out = sp_r;
    out_item.refused       = refused_r;
  end

  assign stat.mode       = item_r.mode;
  assign stat.pair_is_sp = item_r.pair_is_sp;

endmodule

>>> rtl/stack_push_pop_unit.sv
// Top level of the stack push/pop unit: controller plus datapath.
//
//   Channel   Ports                          Handshake
//   input     start, busy, in_item           taken when start is high and busy is low
//   result    out_valid, out_item            one-cycle strobe, always taken
//
// The item is taken in idle, then each stack memory access takes its own step on the
// single memory port, and a pop adds a step to capture its last byte read.
// The result strobes in the cycle after the last step, and a new item may be
// taken in that same cycle.
// Reset clears the stack pointer and the controller; memory contents are
// undefined until written. The receiver cannot stall the result.
module stack_push_pop_unit import spp_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  cmd_t  cmd;
  stat_t stat;

  spp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  spp_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> verif/tb_top.sv
// Testbench for the stack push/pop unit: random and directed stack instructions, scoreboard check.
`timescale 1ns / 100ps

module tb_top;
  import spp_pkg::*;

  localparam int ADDR_BITS   = 16;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;
  localparam int RAND_ITEMS  = 1450;
  localparam int TAIL_ITEMS  = 200;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IN_BITS     = $bits(in_t);

  // Codes with no instruction behind them
  localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  in_t  in_item = '0;
  logic busy;
  logic out_valid;
  out_t out_item;

  stack_push_pop_unit #(.ADDR_BITS(ADDR_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Instructions waiting to be driven and results waiting to arrive
  in_t  instr_q[$];
  out_t pending_results[$];

  int total_items  = 0;
  int sent_cnt     = 0;
  int accepted_cnt = 0;
  int checked_cnt  = 0;
  int refused_cnt  = 0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int mode_cnt [0:7];

  // Predictor state: stack pointer and stack memory
  logic [15:0] pred_sp = '0;
  logic [7:0]  pred_mem [0:STORE_DEPTH-1];

  // Generator shadow: where the stack pointer will be and which bytes hold data
  logic [15:0] gen_sp = '0;
  bit          gen_written [0:STORE_DEPTH-1];

  function automatic void push_byte(logic [7:0] v);
    pred_sp = pred_sp - 16'd1;
    pred_mem[pred_sp[ADDR_BITS-1:0]] = v;
  endfunction

  function automatic logic [7:0] pop_byte();
    logic [7:0] v;
    v = pred_mem[pred_sp[ADDR_BITS-1:0]];
    pred_sp = pred_sp + 16'd1;
    return v;
  endfunction

  // Compute the result of one instruction and advance the predicted state
  function automatic out_t stack_predict(in_t it);
    out_t        r;
    logic [7:0]  st;
    logic [15:0] a1;
    r = '0;
    case (it.mode)
      MODE_PUSH_PAIR: begin
        if (it.pair_is_sp) begin
          r.refused = 1'b1;
        end else begin
          push_byte(it.high_in);
          push_byte(it.low_in);
        end
      end
      MODE_PUSH_ST: begin
        st = {it.sign_in, it.zero_in, 1'b0, it.aux_carry_in, 1'b0, it.parity_in, 1'b1,
              it.carry_in};
        push_byte(it.high_in);
        push_byte(st);
      end
      MODE_POP_PAIR: begin
        if (it.pair_is_sp) begin
          r.refused = 1'b1;
        end else begin
          r.low_out  = pop_byte();
          r.high_out = pop_byte();
        end
      end
      MODE_POP_ST: begin
        st = pop_byte();
        r.carry_out     = st[0];
        r.parity_out    = st[2];
        r.aux_carry_out = st[4];
        r.zero_out      = st[6];
        r.sign_out      = st[7];
        r.high_out      = pop_byte();
      end
      MODE_XCHG: begin
        a1 = pred_sp + 16'd1;
        r.low_out  = pred_mem[pred_sp[ADDR_BITS-1:0]];
        r.high_out = pred_mem[a1[ADDR_BITS-1:0]];
        pred_mem[pred_sp[ADDR_BITS-1:0]] = it.low_in;
        pred_mem[a1[ADDR_BITS-1:0]]      = it.high_in;
      end
      MODE_LOAD_SP: pred_sp = {it.high_in, it.low_in};
      default: ;
    endcase
    r.stack_ptr_out = pred_sp;
    return r;
  endfunction

  // True when both bytes at the top of the stack have been written
  function automatic bit top_readable();
    logic [15:0] a1;
    a1 = gen_sp + 16'd1;
    return gen_written[gen_sp[ADDR_BITS-1:0]] && gen_written[a1[ADDR_BITS-1:0]];
  endfunction

  function automatic void mark_push();
    gen_sp = gen_sp - 16'd1;
    gen_written[gen_sp[ADDR_BITS-1:0]] = 1'b1;
  endfunction

  // Track the shadow pointer and queue the instruction
  function automatic void queue_instr(in_t it);
    case (it.mode)
      MODE_PUSH_PAIR: if (!it.pair_is_sp) begin
        mark_push();
        mark_push();
      end
      MODE_PUSH_ST: begin
        mark_push();
        mark_push();
      end
      MODE_POP_PAIR: if (!it.pair_is_sp) gen_sp = gen_sp + 16'd2;
      MODE_POP_ST:   gen_sp = gen_sp + 16'd2;
      MODE_LOAD_SP:  gen_sp = {it.high_in, it.low_in};
      default: ;
    endcase
    instr_q.push_back(it);
    total_items++;
  endfunction

  // Flags are packed as {carry, parity, aux carry, zero, sign}
  function automatic in_t mk_instr(logic [2:0] m, logic [7:0] h, logic [7:0] l, logic s,
                                   logic [4:0] f);
    return in_t'({m, h, l, s, f});
  endfunction

  // Draw one random instruction that never reads an unwritten byte
  function automatic in_t gen_instr();
    logic [$bits(in_t)-1:0] raw;
    in_t         it;
    int          r;
    logic [15:0] target;
    raw = IN_BITS'($urandom);
    it  = raw;
    it.pair_is_sp = ($urandom_range(0, 7) == 0);
    r = $urandom_range(0, 99);
    if (r < 24)      it.mode = MODE_PUSH_PAIR;
    else if (r < 38) it.mode = MODE_PUSH_ST;
    else if (r < 58) it.mode = MODE_POP_PAIR;
    else if (r < 72) it.mode = MODE_POP_ST;
    else if (r < 84) it.mode = MODE_XCHG;
    else if (r < 94) it.mode = MODE_LOAD_SP;
    else             it.mode = r[0] ? MODE_UNUSED_7 : MODE_UNUSED_6;
    // Turn reads of bytes never written into a push
    if (((it.mode == MODE_POP_PAIR && !it.pair_is_sp) || it.mode == MODE_POP_ST ||
         it.mode == MODE_XCHG) && !top_readable()) begin
      it.mode       = MODE_PUSH_PAIR;
      it.pair_is_sp = 1'b0;
    end
    if (it.mode == MODE_LOAD_SP) begin
      case ($urandom_range(0, 3))
        0: target = 16'($urandom);
        1: begin
          case ($urandom_range(0, 5))
            0: target = 16'h0000;
            1: target = 16'h0001;
            2: target = 16'hFFFF;
            3: target = 16'hFFFE;
            4: target = 16'h8000;
            default: target = 16'h7FFF;
          endcase
        end
        default: target = gen_sp + 16'($urandom_range(0, 6)) - 16'd3;
      endcase
      {it.high_in, it.low_in} = target;
    end
    return it;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_result(out_t want, out_t got);
    check_field("high_out",      32'(want.high_out),      32'(got.high_out));
    check_field("low_out",       32'(want.low_out),       32'(got.low_out));
    check_field("carry_out",     32'(want.carry_out),     32'(got.carry_out));
    check_field("parity_out",    32'(want.parity_out),    32'(got.parity_out));
    check_field("aux_carry_out", 32'(want.aux_carry_out), 32'(got.aux_carry_out));
    check_field("zero_out",      32'(want.zero_out),      32'(got.zero_out));
    check_field("sign_out",      32'(want.sign_out),      32'(got.sign_out));
    check_field("stack_ptr_out", 32'(want.stack_ptr_out), 32'(got.stack_ptr_out));
    check_field("refused",       32'(want.refused),       32'(got.refused));
  endtask

  // Monitor: check results, then predict the item taken at this edge
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: stack_ptr_out 0x%0h",
                 out_item.stack_ptr_out);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_result(want, out_item);
          checked_cnt++;
        end
      end
      if (start && !busy) begin
        want = stack_predict(in_item);
        pending_results.push_back(want);
        mode_cnt[in_item.mode]++;
        if (want.refused) refused_cnt++;
        accepted_cnt++;
      end
    end
  end

  // Driver: hold an item until taken, with random idle bursts between items
  int  gap_left = 0;
  bit  idle_on  = 1'b1;

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && accepted_cnt < sent_cnt) begin
      // hold the current item
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (instr_q.size() > 0) begin
      in_item <= instr_q.pop_front();
      start   <= 1'b1;
      sent_cnt++;
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
      if (idle_on && instr_q.size() > TAIL_ITEMS && $urandom_range(0, 2) == 0)
        gap_left = $urandom_range(1, 9);
    end else begin
      start <= 1'b0;
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    foreach (mode_cnt[i]) mode_cnt[i] = 0;

    // Directed: refused pairs, wrap at both ends, all-zero, all-one and mixed flags, unknown codes
    queue_instr(mk_instr(MODE_POP_PAIR,  8'h00, 8'h00, 1'b1, 5'b00000));
    queue_instr(mk_instr(MODE_PUSH_PAIR, 8'hFF, 8'hFF, 1'b1, 5'b11111));
    queue_instr(mk_instr(MODE_PUSH_PAIR, 8'hFF, 8'h00, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_PUSH_ST,   8'h00, 8'hFF, 1'b0, 5'b11111));
    queue_instr(mk_instr(MODE_PUSH_ST,   8'hFF, 8'h00, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_POP_ST,    8'h00, 8'h00, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_POP_ST,    8'hFF, 8'hFF, 1'b1, 5'b11111));
    queue_instr(mk_instr(MODE_XCHG,      8'hAA, 8'h55, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_XCHG,      8'h00, 8'hFF, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_POP_PAIR,  8'h00, 8'h00, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_UNUSED_6,  8'hFF, 8'hFF, 1'b1, 5'b11111));
    queue_instr(mk_instr(MODE_UNUSED_7,  8'hFF, 8'hFF, 1'b1, 5'b11111));
    queue_instr(mk_instr(MODE_LOAD_SP,   8'h00, 8'h01, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_PUSH_PAIR, 8'h00, 8'hFF, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_XCHG,      8'h5A, 8'hA5, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_POP_PAIR,  8'h00, 8'h00, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_LOAD_SP,   8'hFF, 8'hFF, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_LOAD_SP,   8'h00, 8'h00, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_PUSH_PAIR, 8'h80, 8'h7F, 1'b0, 5'b11111));
    queue_instr(mk_instr(MODE_POP_ST,    8'h00, 8'h00, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_PUSH_ST,   8'h5A, 8'h00, 1'b1, 5'b10101));
    queue_instr(mk_instr(MODE_POP_PAIR,  8'h00, 8'h00, 1'b0, 5'b00000));
    queue_instr(mk_instr(MODE_LOAD_SP,   8'h80, 8'h00, 1'b0, 5'b00000));

    // Random: push/pop traffic over a moving stack pointer
    repeat (RAND_ITEMS) queue_instr(gen_instr());

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every result to arrive, then drain
    while (!(accepted_cnt == total_items && pending_results.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items: %0d push pair, %0d push status, %0d pop pair, %0d pop status,",
             accepted_cnt, mode_cnt[MODE_PUSH_PAIR], mode_cnt[MODE_PUSH_ST],
             mode_cnt[MODE_POP_PAIR], mode_cnt[MODE_POP_ST]);
    $display("%0d exchange, %0d load SP, %0d unknown, %0d refused pairs, %0d checked",
             mode_cnt[MODE_XCHG], mode_cnt[MODE_LOAD_SP],
             mode_cnt[MODE_UNUSED_6] + mode_cnt[MODE_UNUSED_7], refused_cnt, checked_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/spp_pkg.sv
rtl/spp_ctrl.sv
rtl/spp_dp.sv
rtl/stack_push_pop_unit.sv
verif/tb_top.sv
